// ===== sv/mip_downsample_box2x2_core_assert.svh =====
`ifndef MIP_DOWNSAMPLE_BOX2X2_CORE_ASSERT_SVH
`define MIP_DOWNSAMPLE_BOX2X2_CORE_ASSERT_SVH

// checked only out of reset
`define MIPDS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define MIPDS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/mipds_pkg.sv =====
package mipds_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ADDR_W     = $clog2(LINE_DEPTH);
    localparam int WIDTH_W    = 13;
    localparam int HEIGHT_W   = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CH_W       = 8;
    localparam int CHANNELS   = 4;
    localparam int PSUM_W     = CH_W + 1;
    localparam int LINE_W     = CHANNELS * PSUM_W;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    typedef logic [CHANNELS-1:0][PSUM_W-1:0] psum_t;

    typedef struct packed {
        psum_t             hp;
        logic [ADDR_W-1:0] addr;
        logic              wr;
        logic              rd;
        logic              emit;
        logic              h1;
        logic              last;
    } item_t;

endpackage

// ===== sv/mipds_ram.sv =====
module mipds_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/mipds_front.sv =====
module mipds_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [mipds_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mipds_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                                in_valid,
    input  logic                                advance,
    input  logic [mipds_pkg::CH_W-1:0]          red_in,
    input  logic [mipds_pkg::CH_W-1:0]          green_in,
    input  logic [mipds_pkg::CH_W-1:0]          blue_in,
    input  logic [mipds_pkg::CH_W-1:0]          alpha_in,
    output logic                                s1_valid,
    output mipds_pkg::item_t                    s1_item
);

    logic [mipds_pkg::WIDTH_W-1:0]  width_reg;
    logic [mipds_pkg::HEIGHT_W-1:0] height_reg;
    logic [mipds_pkg::COL_W-1:0]    col_reg;
    logic [mipds_pkg::COL_W-1:0]    col_next;
    logic [mipds_pkg::HEIGHT_W-1:0] row_reg;
    logic [mipds_pkg::HEIGHT_W-1:0] row_next;
    logic [mipds_pkg::CHANNELS-1:0][mipds_pkg::CH_W-1:0] held_reg;
    logic [mipds_pkg::CHANNELS-1:0][mipds_pkg::CH_W-1:0] pix;
    logic                           s1_valid_reg;
    mipds_pkg::item_t               s1_item_reg;
    mipds_pkg::item_t               item_next;

    logic [mipds_pkg::WIDTH_W-1:0]  w;
    logic [mipds_pkg::HEIGHT_W-1:0] h;
    logic [mipds_pkg::WIDTH_W-1:0]  w_even;
    logic [mipds_pkg::HEIGHT_W-1:0] h_even;
    logic [mipds_pkg::COL_W-1:0]    ow_m1;
    logic [mipds_pkg::HEIGHT_W-2:0] oh_m1;
    logic                           w1;
    logic                           pair;
    logic                           y_in;
    logic                           accept;

    assign accept = in_valid && advance;
    assign pix    = {alpha_in, blue_in, green_in, red_in};

    always_comb
    begin
        if (width_reg == '0)
        begin
            w = mipds_pkg::WIDTH_W'(1);
        end
        else if (width_reg > mipds_pkg::WIDTH_W'(mipds_pkg::MAX_WIDTH))
        begin
            w = mipds_pkg::WIDTH_W'(mipds_pkg::MAX_WIDTH);
        end
        else
        begin
            w = width_reg;
        end
        h      = (height_reg == '0) ? mipds_pkg::HEIGHT_W'(1) : height_reg;
        w_even = {w[mipds_pkg::WIDTH_W-1:1], 1'b0};
        h_even = {h[mipds_pkg::HEIGHT_W-1:1], 1'b0};
        ow_m1  = (w[mipds_pkg::WIDTH_W-1:1] == '0) ? '0 :
                 w[mipds_pkg::WIDTH_W-1:1] - mipds_pkg::COL_W'(1);
        oh_m1  = (h[mipds_pkg::HEIGHT_W-1:1] == '0) ? '0 :
                 h[mipds_pkg::HEIGHT_W-1:1] - (mipds_pkg::HEIGHT_W-1)'(1);
        w1     = (w == mipds_pkg::WIDTH_W'(1));
        pair   = w1 || (col_reg[0] && ({1'b0, col_reg} < w_even));
        y_in   = (row_reg < h_even);

        for (int c = 0; c < mipds_pkg::CHANNELS; c++)
        begin
            item_next.hp[c] = w1 ? {pix[c], 1'b0} :
                              {1'b0, held_reg[c]} + {1'b0, pix[c]};
        end
        item_next.addr = col_reg[mipds_pkg::COL_W-1:1];
        item_next.h1   = (h == mipds_pkg::HEIGHT_W'(1));
        item_next.wr   = pair && !item_next.h1 && y_in && !row_reg[0];
        item_next.rd   = pair && !item_next.h1 && y_in && row_reg[0];
        item_next.emit = pair && (item_next.h1 || item_next.rd);
        item_next.last = ({1'b0, col_reg[mipds_pkg::COL_W-1:1]} == ow_m1) &&
                         (row_reg[mipds_pkg::HEIGHT_W-1:1] == oh_m1);

        if (({1'b0, col_reg} + mipds_pkg::WIDTH_W'(1)) >= w)
        begin
            col_next = '0;
            if (({1'b0, row_reg} + (mipds_pkg::HEIGHT_W+1)'(1)) >= {1'b0, h})
            begin
                row_next = '0;
            end
            else
            begin
                row_next = row_reg + mipds_pkg::HEIGHT_W'(1);
            end
        end
        else
        begin
            col_next = col_reg + mipds_pkg::COL_W'(1);
            row_next = row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= mipds_pkg::WIDTH_W'(1);
            height_reg   <= mipds_pkg::HEIGHT_W'(1);
            col_reg      <= '0;
            row_reg      <= '0;
            held_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == mipds_pkg::REG_IMAGE_WIDTH)
                begin
                    width_reg <= cfg_data[mipds_pkg::WIDTH_W-1:0];
                end
                else if (cfg_index == mipds_pkg::REG_IMAGE_HEIGHT)
                begin
                    height_reg <= cfg_data[mipds_pkg::HEIGHT_W-1:0];
                end
                col_reg <= '0;
                row_reg <= '0;
            end
            else if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
                if (!w1 && !col_reg[0])
                begin
                    held_reg <= pix;
                end
            end
            if (advance)
            begin
                s1_valid_reg <= accept && (item_next.wr || item_next.emit);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_item_reg <= item_next;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_item  = s1_item_reg;

endmodule

// ===== sv/mipds_back.sv =====
module mipds_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s1_valid,
    input  mipds_pkg::item_t                  s1_item,
    input  logic [mipds_pkg::LINE_W-1:0]      line_q,
    input  logic                              out_stall,
    output logic                              advance,
    output logic                              out_valid,
    output logic [mipds_pkg::CH_W-1:0]        red_out,
    output logic [mipds_pkg::CH_W-1:0]        green_out,
    output logic [mipds_pkg::CH_W-1:0]        blue_out,
    output logic [mipds_pkg::CH_W-1:0]        alpha_out,
    output logic                              last_pixel
);

    logic                 s2_valid_reg;
    mipds_pkg::item_t     s2_item_reg;
    logic                 out_valid_reg;
    logic                 last_reg;
    logic [mipds_pkg::CHANNELS-1:0][mipds_pkg::CH_W-1:0] pix_reg;
    logic [mipds_pkg::CHANNELS-1:0][mipds_pkg::CH_W-1:0] pix_next;
    mipds_pkg::psum_t     line_sum;
    logic [mipds_pkg::PSUM_W:0] total;

    assign advance  = !(out_valid_reg && out_stall);
    assign line_sum = line_q;

    always_comb
    begin
        total = '0;
        for (int c = 0; c < mipds_pkg::CHANNELS; c++)
        begin
            if (s2_item_reg.h1)
            begin
                total = {s2_item_reg.hp[c], 1'b0};
            end
            else
            begin
                total = {1'b0, line_sum[c]} + {1'b0, s2_item_reg.hp[c]};
            end
            pix_next[c] = total[mipds_pkg::PSUM_W:2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s2_valid_reg  <= s1_valid;
            out_valid_reg <= s2_valid_reg && s2_item_reg.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_item_reg <= s1_item;
            pix_reg     <= pix_next;
            last_reg    <= s2_item_reg.last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign red_out    = pix_reg[0];
    assign green_out  = pix_reg[1];
    assign blue_out   = pix_reg[2];
    assign alpha_out  = pix_reg[3];
    assign last_pixel = last_reg;

endmodule

// ===== sv/mip_downsample_box2x2_core.sv =====
// 2x2 box-filter mip step on an RGBA8 raster stream. Takes one source word per
// cycle while in_stall is low and returns one word of the next level, the
// truncated channel mean of each 2x2 block, on the odd column of every odd
// row; last_pixel marks the final word of the image. Odd trailing columns and
// rows are dropped, and a width or height of 1 counts that column or row twice.
// A word passes the s1, s2 and output registers; the pipe holds while out_stall
// holds a pending result. Even-row pair sums go to a 2048 x 36 line memory read
// one row later. Any configuration write restarts the image at (0,0).
module mip_downsample_box2x2_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [mipds_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mipds_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [mipds_pkg::CH_W-1:0]       red_in,
    input  logic [mipds_pkg::CH_W-1:0]       green_in,
    input  logic [mipds_pkg::CH_W-1:0]       blue_in,
    input  logic [mipds_pkg::CH_W-1:0]       alpha_in,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [mipds_pkg::CH_W-1:0]       red_out,
    output logic [mipds_pkg::CH_W-1:0]       green_out,
    output logic [mipds_pkg::CH_W-1:0]       blue_out,
    output logic [mipds_pkg::CH_W-1:0]       alpha_out,
    output logic                             last_pixel
);

    logic                             advance;
    logic                             s1_valid;
    mipds_pkg::item_t                 s1_item;
    logic [mipds_pkg::LINE_W-1:0]     line_q;

    assign in_stall = !advance;

    mipds_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .advance   (advance),
        .red_in    (red_in),
        .green_in  (green_in),
        .blue_in   (blue_in),
        .alpha_in  (alpha_in),
        .s1_valid  (s1_valid),
        .s1_item   (s1_item)
    );

    mipds_ram #(
        .WIDTH (mipds_pkg::LINE_W),
        .DEPTH (mipds_pkg::LINE_DEPTH)
    ) u_line (
        .clk   (clk),
        .we    (advance && s1_valid && s1_item.wr),
        .waddr (s1_item.addr),
        .wdata (s1_item.hp),
        .re    (advance && s1_valid && s1_item.rd),
        .raddr (s1_item.addr),
        .rdata (line_q)
    );

    mipds_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .s1_valid   (s1_valid),
        .s1_item    (s1_item),
        .line_q     (line_q),
        .out_stall  (out_stall),
        .advance    (advance),
        .out_valid  (out_valid),
        .red_out    (red_out),
        .green_out  (green_out),
        .blue_out   (blue_out),
        .alpha_out  (alpha_out),
        .last_pixel (last_pixel)
    );

endmodule

// ===== sv/mipds_checker.sv =====
`include "mip_downsample_box2x2_core_assert.svh"

module mipds_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_stall,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic [mipds_pkg::CH_W-1:0] red_out,
    input logic [mipds_pkg::CH_W-1:0] green_out,
    input logic [mipds_pkg::CH_W-1:0] blue_out,
    input logic [mipds_pkg::CH_W-1:0] alpha_out,
    input logic                       last_pixel
);

    `MIPDS_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "output word during reset")
    `MIPDS_ASSERT(a_stall_back, out_valid && out_stall |-> in_stall, "input taken while output held")
    `MIPDS_ASSERT(a_no_idle_stall, !out_valid |-> !in_stall, "input stalled with empty output")
    `MIPDS_ASSERT(a_hold_word, out_valid && out_stall |=> out_valid && $stable({red_out, green_out, blue_out, alpha_out, last_pixel}), "held word changed")

endmodule

bind mip_downsample_box2x2_core mipds_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .red_out    (red_out),
    .green_out  (green_out),
    .blue_out   (blue_out),
    .alpha_out  (alpha_out),
    .last_pixel (last_pixel)
);

// ===== sim/mip_downsample_box2x2_core_tb.sv =====
`timescale 1ns / 100ps

module mip_downsample_box2x2_core_tb;

    localparam logic [mipds_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [mipds_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;
    localparam int RANDOM_PIXELS = 700;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 20;
    localparam int LONG_HOLD     = 300;
    localparam int LIMIT_CYCLES  = 400000;

    typedef struct packed {
        logic [mipds_pkg::CH_W-1:0] red;
        logic [mipds_pkg::CH_W-1:0] green;
        logic [mipds_pkg::CH_W-1:0] blue;
        logic [mipds_pkg::CH_W-1:0] alpha;
    } rgba_t;

    typedef struct packed {
        rgba_t px;
        logic  last;
    } mip_word_t;

    typedef enum logic [1:0] {RX_FLOW, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_pattern_e;

    class mip_scoreboard;
        logic [mipds_pkg::WIDTH_W-1:0]  width_reg;
        logic [mipds_pkg::HEIGHT_W-1:0] height_reg;
        logic [mipds_pkg::COL_W-1:0]    col_pos;
        logic [mipds_pkg::HEIGHT_W-1:0] row_pos;
        logic [mipds_pkg::CH_W-1:0]     held [mipds_pkg::CHANNELS];
        logic [mipds_pkg::PSUM_W-1:0]   pair_line [mipds_pkg::LINE_DEPTH][mipds_pkg::CHANNELS];
        mip_word_t                      pending_words [$];
        int                             pixels_in;
        int                             words_checked;
        int                             mismatches;

        function new();
            int s, c;
            width_reg     = 1;
            height_reg    = 1;
            col_pos       = '0;
            row_pos       = '0;
            pixels_in     = 0;
            words_checked = 0;
            mismatches    = 0;
            for (c = 0; c < mipds_pkg::CHANNELS; c++)
                held[c] = '0;
            for (s = 0; s < mipds_pkg::LINE_DEPTH; s++)
                for (c = 0; c < mipds_pkg::CHANNELS; c++)
                    pair_line[s][c] = '0;
        endfunction

        function void write_register(logic [mipds_pkg::CFG_IDX_W-1:0] idx,
                                     logic [mipds_pkg::CFG_DATA_W-1:0] data);
            if (idx == mipds_pkg::REG_IMAGE_WIDTH)
                width_reg = data[mipds_pkg::WIDTH_W-1:0];
            else if (idx == mipds_pkg::REG_IMAGE_HEIGHT)
                height_reg = data[mipds_pkg::HEIGHT_W-1:0];
            col_pos = '0;
            row_pos = '0;
        endfunction

        function int pending();
            return pending_words.size();
        endfunction

        function void note_pixel(rgba_t p);
            int w, h, ow, oh, x, y, slot, c;
            logic [mipds_pkg::CH_W-1:0]   ch [mipds_pkg::CHANNELS];
            logic [mipds_pkg::PSUM_W-1:0] hp [mipds_pkg::CHANNELS];
            logic [mipds_pkg::PSUM_W:0]   sum [mipds_pkg::CHANNELS];
            bit paired, fire;
            mip_word_t word;
            pixels_in++;
            w = (width_reg == 0) ? 1 : width_reg;
            if (w > mipds_pkg::MAX_WIDTH)
                w = mipds_pkg::MAX_WIDTH;
            h  = (height_reg == 0) ? 1 : height_reg;
            ow = (w / 2 > 0) ? w / 2 : 1;
            oh = (h / 2 > 0) ? h / 2 : 1;
            x  = col_pos;
            y  = row_pos;
            ch[0] = p.red;
            ch[1] = p.green;
            ch[2] = p.blue;
            ch[3] = p.alpha;
            paired = 0;
            fire   = 0;
            if (w == 1) begin
                for (c = 0; c < mipds_pkg::CHANNELS; c++)
                    hp[c] = {ch[c], 1'b0};
                paired = 1;
            end
            else if (x % 2 == 0) begin
                held = ch;
            end
            else if (x < 2 * ow) begin
                for (c = 0; c < mipds_pkg::CHANNELS; c++)
                    hp[c] = held[c] + ch[c];
                paired = 1;
            end
            if (paired) begin
                slot = (x / 2) % mipds_pkg::LINE_DEPTH;
                if (h == 1) begin
                    for (c = 0; c < mipds_pkg::CHANNELS; c++)
                        sum[c] = {hp[c], 1'b0};
                    fire = 1;
                end
                else if (y < 2 * oh) begin
                    if (y % 2 == 0) begin
                        for (c = 0; c < mipds_pkg::CHANNELS; c++)
                            pair_line[slot][c] = hp[c];
                    end
                    else begin
                        for (c = 0; c < mipds_pkg::CHANNELS; c++)
                            sum[c] = pair_line[slot][c] + hp[c];
                        fire = 1;
                    end
                end
            end
            if (fire) begin
                word.px.red   = sum[0][mipds_pkg::PSUM_W:2];
                word.px.green = sum[1][mipds_pkg::PSUM_W:2];
                word.px.blue  = sum[2][mipds_pkg::PSUM_W:2];
                word.px.alpha = sum[3][mipds_pkg::PSUM_W:2];
                word.last     = (x / 2 == ow - 1) && (y / 2 == oh - 1);
                pending_words = {pending_words, word};
            end
            if (x + 1 >= w) begin
                col_pos = '0;
                row_pos = (y + 1 >= h) ? '0 : mipds_pkg::HEIGHT_W'(y + 1);
            end
            else begin
                col_pos = mipds_pkg::COL_W'(x + 1);
            end
        endfunction

        function void flag_error(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("MISMATCH: %s", msg);
        endfunction

        function void check_word(mip_word_t got);
            mip_word_t want;
            words_checked++;
            if (pending_words.size() == 0) begin
                flag_error($sformatf("unexpected word r=%0d g=%0d b=%0d a=%0d last=%0b",
                    got.px.red, got.px.green, got.px.blue, got.px.alpha, got.last));
            end
            else begin
                want = pending_words.pop_front();
                if (got.px.red !== want.px.red || got.px.green !== want.px.green ||
                    got.px.blue !== want.px.blue || got.px.alpha !== want.px.alpha ||
                    got.last !== want.last)
                    flag_error($sformatf(
                        {"word %0d expected r=%0d g=%0d b=%0d a=%0d last=%0b, ",
                         "got r=%0d g=%0d b=%0d a=%0d last=%0b"},
                        words_checked, want.px.red, want.px.green, want.px.blue, want.px.alpha,
                        want.last, got.px.red, got.px.green, got.px.blue, got.px.alpha, got.last));
            end
        endfunction
    endclass

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_write;
    logic [mipds_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [mipds_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                             in_valid;
    logic                             in_stall;
    logic [mipds_pkg::CH_W-1:0]       red_in;
    logic [mipds_pkg::CH_W-1:0]       green_in;
    logic [mipds_pkg::CH_W-1:0]       blue_in;
    logic [mipds_pkg::CH_W-1:0]       alpha_in;
    logic                             out_valid;
    logic                             out_stall;
    logic [mipds_pkg::CH_W-1:0]       red_out;
    logic [mipds_pkg::CH_W-1:0]       green_out;
    logic [mipds_pkg::CH_W-1:0]       blue_out;
    logic [mipds_pkg::CH_W-1:0]       alpha_out;
    logic                             last_pixel;

    mip_scoreboard mip_sb;
    int cycle_count;
    int stalled_offers;
    int reg_writes;
    int hold_requests;
    int burst_left;

    mip_downsample_box2x2_core uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .red_in     (red_in),
        .green_in   (green_in),
        .blue_in    (blue_in),
        .alpha_in   (alpha_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .red_out    (red_out),
        .green_out  (green_out),
        .blue_out   (blue_out),
        .alpha_out  (alpha_out),
        .last_pixel (last_pixel)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (in_valid && in_stall)
            stalled_offers++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Verification failed");
            $finish;
        end
    end

    // receiver: own stall pattern, long holds on request
    initial
    begin
        int          holds_served;
        int          hold_left;
        int          seg_left;
        rx_pattern_e pattern;
        logic        stall_next;
        mip_word_t   got;
        holds_served = 0;
        hold_left    = 0;
        seg_left     = 0;
        pattern      = RX_FLOW;
        out_stall    = 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall) begin
                got.px.red   = red_out;
                got.px.green = green_out;
                got.px.blue  = blue_out;
                got.px.alpha = alpha_out;
                got.last     = last_pixel;
                mip_sb.check_word(got);
            end
            if (hold_left > 0) begin
                hold_left--;
                stall_next = 1'b1;
            end
            else if (holds_served != hold_requests) begin
                holds_served++;
                hold_left  = LONG_HOLD - 1;
                stall_next = 1'b1;
            end
            else begin
                if (seg_left == 0) begin
                    pattern  = rx_pattern_e'($urandom_range(0, 3));
                    seg_left = $urandom_range(16, 160);
                end
                seg_left--;
                case (pattern)
                    RX_FLOW:   stall_next = 1'b0;
                    RX_LIGHT:  stall_next = ($urandom_range(0, 3) == 0);
                    RX_HEAVY:  stall_next = ($urandom_range(0, 3) != 0);
                    default:   stall_next = seg_left[0];
                endcase
            end
            out_stall <= stall_next;
        end
    end

    function automatic rgba_t random_pixel();
        rgba_t p;
        p = $urandom;
        if ($urandom_range(0, 7) == 0) begin
            p.red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            p.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            p.blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            p.alpha = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end
        return p;
    endfunction

    task automatic send_pixel(input rgba_t p);
        red_in   <= p.red;
        green_in <= p.green;
        blue_in  <= p.blue;
        alpha_in <= p.alpha;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        mip_sb.note_pixel(p);
    endtask

    task automatic pause_sender(input int n);
        if (n > 0) begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // drop valid and hold until every expected word is out
    task automatic wait_quiet();
        in_valid <= 1'b0;
        while (mip_sb.pending() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [mipds_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mipds_pkg::CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        mip_sb.write_register(idx, data);
        reg_writes++;
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic [mipds_pkg::CFG_DATA_W-1:0] w,
                             input logic [mipds_pkg::CFG_DATA_W-1:0] h);
        wait_quiet();
        write_reg(mipds_pkg::REG_IMAGE_WIDTH, w);
        write_reg(mipds_pkg::REG_IMAGE_HEIGHT, h);
    endtask

    task automatic restart_image();
        wait_quiet();
        write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
                  mipds_pkg::CFG_DATA_W'($urandom));
    endtask

    task automatic feed(input int count, input bit gapped);
        for (int k = 0; k < count; k++) begin
            if (gapped) begin
                if (burst_left == 0) begin
                    pause_sender($urandom_range(0, 9));
                    burst_left = $urandom_range(1, 40);
                end
                burst_left--;
            end
            send_pixel(random_pixel());
        end
    endtask

    initial
    begin
        int    start_count;
        int    w, h, ew, eh, images, total;
        bit    gapped;
        rgba_t p;
        mip_sb         = new();
        cycle_count    = 0;
        stalled_offers = 0;
        reg_writes     = 0;
        hold_requests  = 0;
        burst_left     = 0;
        clk            = 1'b0;
        rst_n          = 1'b0;
        cfg_write      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        red_in         = '0;
        green_in       = '0;
        blue_in        = '0;
        alpha_in       = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset sizes: every pixel is its own image
        send_pixel('{8'h00, 8'h00, 8'h00, 8'h00});
        send_pixel('{8'hFF, 8'hFF, 8'hFF, 8'hFF});
        configure(16'd0, 16'd0);
        send_pixel('{8'hAA, 8'h55, 8'h0F, 8'hF0});
        // odd sizes drop the last column and row, sizes of 1 are counted twice
        configure(16'd3, 16'd3);
        for (int k = 0; k < 9; k++) begin
            p.red   = 8'hFF - 8'(k);
            p.green = 8'(k * 37);
            p.blue  = k[0] ? 8'hFF : 8'h00;
            p.alpha = 8'(k * 3 + 1);
            send_pixel(p);
        end
        configure(16'd2, 16'd1);
        send_pixel('{8'h00, 8'hFF, 8'h01, 8'hFE});
        send_pixel('{8'hFF, 8'h00, 8'hFE, 8'h01});
        configure(16'd1, 16'd2);
        send_pixel('{8'h80, 8'h7F, 8'hFF, 8'h00});
        send_pixel('{8'h7F, 8'h80, 8'hFF, 8'h01});
        // restart mid-image through a spare register index
        configure(16'd2, 16'd2);
        send_pixel('{8'hFF, 8'hFF, 8'hFF, 8'hFF});
        send_pixel('{8'hFF, 8'hFF, 8'hFF, 8'hFF});
        wait_quiet();
        write_reg(REG_SPARE_HI, 16'hFFFF);
        for (int k = 0; k < 4; k++)
            send_pixel('{8'(k * 85), 8'hFF - 8'(k * 85), 8'(k), 8'hFE});

        // widest image, receiver held off while the sender keeps offering; then tall and max-width images
        configure(16'hFFFF, 16'd1);
        hold_requests++;
        feed(80, 0);
        configure(16'd2, 16'hFFFF);
        feed(20, 1);
        wait_quiet();
        feed(20, 1);
        configure(16'd4096, 16'd2);
        feed(40, 1);

        start_count = mip_sb.pixels_in;
        while (mip_sb.pixels_in - start_count < RANDOM_PIXELS) begin
            case ($urandom_range(0, 9))
                0:       w = $urandom_range(0, 1);
                7, 8:    w = $urandom_range(10, 40);
                9:       w = $urandom_range(41, 200);
                default: w = $urandom_range(2, 9);
            endcase
            if (w > 40)
                h = $urandom_range(0, 2);
            else if (w > 9)
                h = $urandom_range(0, 5);
            else
                h = $urandom_range(0, 12);
            configure(mipds_pkg::CFG_DATA_W'(w), mipds_pkg::CFG_DATA_W'(h));
            ew     = (w == 0) ? 1 : w;
            eh     = (h == 0) ? 1 : h;
            total  = ew * eh;
            images = (total > 200) ? 1 : $urandom_range(1, 3);
            gapped = ($urandom_range(0, 3) != 0);
            for (int n = 0; n < images; n++) begin
                if ($urandom_range(0, 7) == 0) begin
                    feed($urandom_range(0, total - 1), gapped);
                    restart_image();
                end
                else begin
                    feed(total, gapped);
                end
            end
            if ($urandom_range(0, 9) == 0)
                wait_quiet();
        end

        in_valid <= 1'b0;
        while (mip_sb.pending() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d source pixels and %0d mip words across %0d register writes,",
            mip_sb.pixels_in, mip_sb.words_checked, reg_writes);
        $display("with %0d long output holds, %0d stalled input cycles, %0d words left over.",
            hold_requests, stalled_offers, mip_sb.pending());
        if (mip_sb.mismatches == 0 && mip_sb.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== mip_downsample_box2x2_core.f =====
+incdir+sv
sv/mipds_pkg.sv
sv/mipds_ram.sv
sv/mipds_front.sv
sv/mipds_back.sv
sv/mip_downsample_box2x2_core.sv
sv/mipds_checker.sv
sim/mip_downsample_box2x2_core_tb.sv
